// ===== src/sha_pkg.sv =====
// Shared types, constants and functions of the SHA-256 stream hasher.
package sha_pkg;

	localparam int unsigned WORD_W  = 32;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned NWORDS  = 8;
	localparam int unsigned NROUNDS = 64;
	localparam int unsigned WIN_N   = 16;
	localparam int unsigned FILL_W  = $clog2(NROUNDS);
	localparam int unsigned BLKCNT_W = 64 - 9;

	localparam logic [BYTE_W-1:0] PAD_MARK = 8'h80;
	localparam logic [FILL_W-1:0] LEN_POS  = 6'd56;
	localparam logic [FILL_W-1:0] FILL_TOP = 6'd63;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [NWORDS-1:0][WORD_W-1:0] word_arr_t;

	localparam word_arr_t H_INIT = {
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667};

	localparam word_t ROUND_K [NROUNDS] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROUND,
		ST_ADD,
		ST_PAD,
		ST_EMIT
	} state_t;

	// Padding phases
	typedef enum logic [1:0] {
		PH_MARK,
		PH_ZERO,
		PH_LEN
	} pad_phase_t;

	// Control of the message window
	typedef struct packed {
		logic              push;
		logic [BYTE_W-1:0] byte_v;
		logic              step;
	} msg_ctrl_t;

	// Control of the round unit
	typedef struct packed {
		logic              load;
		logic              step;
		logic              add;
		logic              init;
		logic [FILL_W-1:0] round;
	} rnd_ctrl_t;

	function automatic word_t ror32(input word_t x, input int unsigned n);
		return (x >> n) | (x << (WORD_W - n));
	endfunction

	function automatic word_t big_sig0(input word_t x);
		return ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
	endfunction

	function automatic word_t big_sig1(input word_t x);
		return ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
	endfunction

	function automatic word_t sml_sig0(input word_t x);
		return ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
	endfunction

	function automatic word_t sml_sig1(input word_t x);
		return ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
	endfunction

endpackage

// ===== src/sha_msg_if.sv =====
// Request channel of the hasher: one absorb or finish request per handshake.
interface sha_msg_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] data_byte;

	modport source (output valid, output action, output data_byte, input ready);
	modport sink   (input valid, input action, input data_byte, output ready);
endinterface

// ===== src/sha_dig_if.sv =====
// Digest channel of the hasher: one 32-bit digest word per handshake.
interface sha_dig_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	modport source (output valid, output digest_word, output word_index,
		output last_word, input ready);
	modport sink   (input valid, input digest_word, input word_index,
		input last_word, output ready);
endinterface

// ===== src/sha256_stream_hasher_top.sv =====
// Top level of the SHA-256 stream hasher: request handling and sequencer.
//
// Requests arrive on msg: action 0 absorbs data_byte, action 1 ends the
// message. Digest words leave on digest, word 0 first, last_word on word 7.
// The 64th byte of a block also starts the compression, which runs all
// rounds on the single round unit and then folds the result into the
// chain. msg.ready is low while a block is compressed, while padding runs
// and while the digest is delivered. A finish pushes one pad byte per
// cycle while no block is compressed (0x80, zeros, eight length bytes,
// with an idle step before the length) through the same path, with one or
// two compressions depending on the fill. The eight digest words then go
// out one per cycle while digest.ready is high. A stalled receiver holds
// the current word; nothing else moves meanwhile.
// After word 7 is taken the chain, byte count and bit count return to
// their initial values and msg.ready rises again.
// Reset sets the initial hash value, clears the counts and leaves the
// block buffer contents undefined; the block is ready right after reset.
module sha256_stream_hasher_top import sha_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	sha_msg_if.sink   msg,
	sha_dig_if.source digest
);

	state_t            state_q, state_nxt;
	pad_phase_t        phase_q, phase_nxt;
	logic [FILL_W-1:0] fill_q;
	logic [FILL_W-1:0] round_q;
	logic [BLKCNT_W-1:0] blocks_q;
	logic [63:0]       len_q;
	logic [2:0]        len_cnt_q;
	logic [2:0]        word_idx_q;
	logic              pad_done_q;
	logic              pad_active_q;

	msg_ctrl_t         mctl;
	rnd_ctrl_t         rctl;
	word_t             w_word;
	word_arr_t         chain;
	logic              start_pad;
	logic              len_push;
	logic              emit_done;

	sha_msg u_msg (
		.clk    (clk),
		.ctrl   (mctl),
		.w_word (w_word)
	);

	sha_round u_round (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (rctl),
		.w_word (w_word),
		.chain  (chain)
	);

	// Next state and strobes
	always_comb begin
		state_nxt   = state_q;
		phase_nxt   = phase_q;
		mctl.push   = 1'b0;
		mctl.byte_v = msg.data_byte;
		mctl.step   = 1'b0;
		rctl.load   = 1'b0;
		rctl.step   = 1'b0;
		rctl.add    = 1'b0;
		rctl.init   = 1'b0;
		rctl.round  = round_q;
		msg.ready   = 1'b0;
		start_pad   = 1'b0;
		len_push    = 1'b0;
		emit_done   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				msg.ready = 1'b1;
				if (msg.valid) begin
					if (msg.action) begin
						start_pad = 1'b1;
						phase_nxt = PH_MARK;
						state_nxt = ST_PAD;
					end else begin
						mctl.push = 1'b1;
					end
				end
			end
			ST_PAD: begin
				unique case (phase_q)
					PH_MARK: begin
						mctl.push   = 1'b1;
						mctl.byte_v = PAD_MARK;
						phase_nxt   = PH_ZERO;
					end
					PH_ZERO: begin
						if (fill_q == LEN_POS) begin
							phase_nxt = PH_LEN;
						end else begin
							mctl.push   = 1'b1;
							mctl.byte_v = '0;
						end
					end
					PH_LEN: begin
						mctl.push   = 1'b1;
						mctl.byte_v = len_q[63 -: BYTE_W];
						len_push    = 1'b1;
					end
					default: begin
						phase_nxt = PH_MARK;
					end
				endcase
			end
			ST_ROUND: begin
				mctl.step = 1'b1;
				rctl.step = 1'b1;
				if (round_q == FILL_W'(NROUNDS - 1)) begin
					state_nxt = ST_ADD;
				end
			end
			ST_ADD: begin
				rctl.add = 1'b1;
				if (pad_done_q) begin
					state_nxt = ST_EMIT;
				end else if (pad_active_q) begin
					state_nxt = ST_PAD;
				end else begin
					state_nxt = ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (digest.ready && word_idx_q == 3'(NWORDS - 1)) begin
					emit_done = 1'b1;
					rctl.init = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
		// A full buffer starts a compression
		if (mctl.push && fill_q == FILL_TOP) begin
			rctl.load = 1'b1;
			state_nxt = ST_ROUND;
		end
	end

	// Sequencer and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			phase_q      <= PH_MARK;
			fill_q       <= '0;
			round_q      <= '0;
			blocks_q     <= '0;
			len_cnt_q    <= '0;
			word_idx_q   <= '0;
			pad_done_q   <= 1'b0;
			pad_active_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			phase_q <= phase_nxt;
			if (mctl.push) begin
				fill_q <= fill_q + 1'b1;
			end
			if (rctl.step) begin
				round_q <= round_q + 1'b1;
			end
			if (rctl.add) begin
				blocks_q <= blocks_q + 1'b1;
			end
			if (start_pad) begin
				pad_active_q <= 1'b1;
				len_cnt_q    <= '0;
			end
			if (len_push) begin
				len_cnt_q <= len_cnt_q + 1'b1;
				if (len_cnt_q == 3'd7) begin
					pad_done_q <= 1'b1;
				end
			end
			// Advance the digest word on each taken request
			if (state_q == ST_EMIT && digest.ready) begin
				word_idx_q <= word_idx_q + 1'b1;
			end
			if (emit_done) begin
				blocks_q     <= '0;
				pad_done_q   <= 1'b0;
				pad_active_q <= 1'b0;
			end
		end
	end

	// Capture the message length, then shift out one byte per length push
	always_ff @(posedge clk) begin
		if (start_pad) begin
			len_q <= {blocks_q, fill_q, 3'b000};
		end else if (len_push) begin
			len_q <= {len_q[63-BYTE_W:0], BYTE_W'(0)};
		end
	end

	assign digest.valid       = (state_q == ST_EMIT);
	assign digest.digest_word = chain[word_idx_q];
	assign digest.word_index  = word_idx_q;
	assign digest.last_word   = (word_idx_q == 3'(NWORDS - 1));

	// The round counter wraps into the fold cycle
	a_round_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND && round_q == FILL_W'(NROUNDS - 1)) |=> state_q == ST_ADD)
		else $error("round sequence did not end in the chain fold");

	// A compression always starts at round zero
	a_round_start: assert property (@(posedge clk) disable iff (!arst_n)
		rctl.load |=> (state_q == ST_ROUND && round_q == '0))
		else $error("compression did not start at round zero");

	// Digest words only after the length is fully padded in
	a_emit_padded: assert property (@(posedge clk) disable iff (!arst_n)
		digest.valid |-> (pad_done_q && fill_q == '0))
		else $error("digest offered before padding completed");

	// A finished digest leaves the counts cleared
	a_emit_clear: assert property (@(posedge clk) disable iff (!arst_n)
		emit_done |=> (blocks_q == '0 && !pad_active_q && word_idx_q == '0))
		else $error("state not cleared after digest");

endmodule

// ===== src/sha_msg.sv =====
// Block buffer and message schedule window, one shift register for both.
module sha_msg import sha_pkg::*; (
	input  logic      clk,
	input  msg_ctrl_t ctrl,
	output word_t     w_word
);

	word_t win_q [WIN_N];
	word_t w_new;

	// Next schedule word from the sliding window
	assign w_new  = sml_sig1(win_q[14]) + win_q[9] + sml_sig0(win_q[1]) + win_q[0];
	assign w_word = win_q[0];

	// Shift in a byte while filling, shift a word per round while compressing
	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			for (int i = 0; i < WIN_N - 1; i++) begin
				win_q[i] <= {win_q[i][WORD_W-BYTE_W-1:0], win_q[i+1][WORD_W-1 -: BYTE_W]};
			end
			win_q[WIN_N-1] <= {win_q[WIN_N-1][WORD_W-BYTE_W-1:0], ctrl.byte_v};
		end else if (ctrl.step) begin
			for (int i = 0; i < WIN_N - 1; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[WIN_N-1] <= w_new;
		end
	end

endmodule

// ===== src/sha_round.sv =====
// Shared round unit: working variables and the chain value.
module sha_round import sha_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  rnd_ctrl_t ctrl,
	input  word_t     w_word,
	output word_arr_t chain
);

	word_arr_t chain_q;
	word_arr_t v_q;
	word_t     t1;
	word_t     t2;
	word_t     ch;
	word_t     maj;

	// One compression round
	always_comb begin
		ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t1  = v_q[7] + big_sig1(v_q[4]) + ch + ROUND_K[ctrl.round] + w_word;
		t2  = big_sig0(v_q[0]) + maj;
	end

	// Load from chain, then rotate the working variables each round
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			v_q <= chain_q;
		end else if (ctrl.step) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	// Fold the block result into the chain; restart after a digest
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= H_INIT;
		end else if (ctrl.init) begin
			chain_q <= H_INIT;
		end else if (ctrl.add) begin
			for (int i = 0; i < NWORDS; i++) begin
				chain_q[i] <= chain_q[i] + v_q[i];
			end
		end
	end

	assign chain = chain_q;

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench of the SHA-256 stream hasher: byte messages in, digest words checked.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ITEM_TARGET = 360;
	localparam int LONG_HOLD   = 400;
	localparam int DRAIN_WAIT  = 150;

	localparam bit [31:0] INIT_CHAIN [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	localparam bit [31:0] RK [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

	localparam bit ACT_ABSORB = 1'b0;
	localparam bit ACT_FINISH = 1'b1;

	typedef struct {
		bit [31:0] word;
		bit [2:0]  index;
		bit        last;
	} digest_entry_t;

	// Predictor of the hasher plus the queue of digest words still due
	class sha256_predictor;
		bit [31:0]     chain [8];
		bit [7:0]      block_bytes [64];
		int            fill;
		bit [63:0]     done_bits;
		digest_entry_t due_words [$];
		int            mismatches;

		function new();
			restart();
			mismatches = 0;
		endfunction

		function void restart();
			foreach (chain[i])
				chain[i] = INIT_CHAIN[i];
			fill      = 0;
			done_bits = '0;
		endfunction

		function bit [31:0] rot_right(input bit [31:0] x, input int n);
			return (x >> n) | (x << (32 - n));
		endfunction

		function void compress_block();
			bit [31:0] w [64];
			bit [31:0] a, b, c, d, e, f, g, h;
			bit [31:0] s0, s1, t1, t2;
			for (int t = 0; t < 16; t++)
				w[t] = {block_bytes[4*t], block_bytes[4*t+1],
					block_bytes[4*t+2], block_bytes[4*t+3]};
			for (int t = 16; t < 64; t++) begin
				s0 = rot_right(w[t-15], 7) ^ rot_right(w[t-15], 18) ^ (w[t-15] >> 3);
				s1 = rot_right(w[t-2], 17) ^ rot_right(w[t-2], 19) ^ (w[t-2] >> 10);
				w[t] = w[t-16] + s0 + w[t-7] + s1;
			end
			{a, b, c, d, e, f, g, h} = {chain[0], chain[1], chain[2], chain[3],
				chain[4], chain[5], chain[6], chain[7]};
			for (int t = 0; t < 64; t++) begin
				s1 = rot_right(e, 6) ^ rot_right(e, 11) ^ rot_right(e, 25);
				t1 = h + s1 + ((e & f) ^ (~e & g)) + RK[t] + w[t];
				s0 = rot_right(a, 2) ^ rot_right(a, 13) ^ rot_right(a, 22);
				t2 = s0 + ((a & b) ^ (a & c) ^ (b & c));
				h = g; g = f; f = e; e = d + t1;
				d = c; c = b; b = a; a = t1 + t2;
			end
			chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
			chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
		endfunction

		function void absorb_byte(input bit [7:0] v);
			block_bytes[fill] = v;
			fill++;
			if (fill == 64) begin
				compress_block();
				done_bits += 64'd512;
				fill = 0;
			end
		endfunction

		// Advance the model by one accepted request
		function void note_request(input bit act, input bit [7:0] v);
			bit [63:0]     total;
			digest_entry_t ent;
			if (act == ACT_ABSORB) begin
				absorb_byte(v);
				return;
			end
			total = done_bits + 64'(fill * 8);
			absorb_byte(8'h80);
			while (fill != 56)
				absorb_byte(8'h00);
			for (int i = 0; i < 8; i++)
				absorb_byte(total[63 - 8*i -: 8]);
			for (int i = 0; i < 8; i++) begin
				ent.word  = chain[i];
				ent.index = 3'(i);
				ent.last  = (i == 7);
				due_words.insert(due_words.size(), ent);
			end
			restart();
		endfunction

		// Compare one delivered digest word with the oldest one due
		function void check_word(input logic [31:0] w, input logic [2:0] idx,
			input logic lst);
			digest_entry_t ent;
			if (due_words.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected digest word %h index %0d last %b", w, idx, lst);
				return;
			end
			ent = due_words.pop_front();
			if (w !== ent.word || idx !== ent.index || lst !== ent.last) begin
				mismatches++;
				if (mismatches <= 10)
					$display("digest mismatch: expected %h/%0d/%b got %h/%0d/%b",
						ent.word, ent.index, ent.last, w, idx, lst);
			end
		endfunction

		function int pending();
			return due_words.size();
		endfunction
	endclass

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	sha_msg_if msg_ch ();
	sha_dig_if dig_ch ();

	sha256_stream_hasher_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg_ch),
		.digest (dig_ch)
	);

	sha256_predictor hasher_model = new();

	int requests_taken = 0;
	int burst_left     = 0;
	bit random_phase   = 1'b0;
	bit long_hold_done = 1'b0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Run limit, far above the slowest legal run
	initial begin : run_limit
		#(2_000_000);
		$display("testbench: FAIL");
		$finish;
	end

	// Check every digest word taken by the receiver
	always @(posedge clk) begin
		if (arst_n && dig_ch.valid === 1'b1 && dig_ch.ready === 1'b1)
			hasher_model.check_word(dig_ch.digest_word, dig_ch.word_index,
				dig_ch.last_word);
	end

	// Stall the receiver on its own pattern, with one long hold-off
	initial begin : digest_receiver
		int mode;
		int span;
		dig_ch.ready <= 1'b0;
		while (!arst_n)
			@(posedge clk);
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(1, 40);
			for (int i = 0; i < span; i++) begin
				if (!long_hold_done && random_phase && dig_ch.valid === 1'b1 &&
					msg_ch.valid === 1'b1) begin
					dig_ch.ready <= 1'b0;
					repeat (LONG_HOLD) @(posedge clk);
					long_hold_done = 1'b1;
				end
				case (mode)
					0: dig_ch.ready <= 1'b1;
					1: dig_ch.ready <= ($urandom_range(0, 3) != 0);
					2: dig_ch.ready <= i[0];
					default: dig_ch.ready <= ($urandom_range(0, 4) == 0);
				endcase
				@(posedge clk);
			end
		end
	end

	// Drop valid for a random gap at the end of each burst
	task automatic pace_sender();
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		msg_ch.valid <= 1'b0;
		repeat ($urandom_range(1, 8)) @(posedge clk);
		burst_left = $urandom_range(0, 60);
	endtask

	// Offer one request and hold it until accepted
	task automatic send_request(input bit act, input bit [7:0] v);
		msg_ch.valid     <= 1'b1;
		msg_ch.action    <= act;
		msg_ch.data_byte <= v;
		do
			@(posedge clk);
		while (msg_ch.ready !== 1'b1);
		hasher_model.note_request(act, v);
		requests_taken++;
		pace_sender();
	endtask

	task automatic send_message(input int len);
		for (int j = 0; j < len; j++)
			send_request(ACT_ABSORB, 8'($urandom_range(0, 255)));
		send_request(ACT_FINISH, 8'($urandom_range(0, 255)));
	endtask

	// Hold the sender until every due digest word has come
	task automatic wait_drained();
		msg_ch.valid <= 1'b0;
		while (hasher_model.pending() != 0)
			@(posedge clk);
	endtask

	// Message lengths: mostly short, some at the padding boundaries
	function automatic int pick_length();
		int pick;
		pick = $urandom_range(0, 9);
		case (pick)
			0, 1, 2, 3, 4: return $urandom_range(0, 12);
			5: return 55 + 8 * $urandom_range(0, 1) - $urandom_range(0, 1) * 0
				+ ($urandom_range(0, 1) ? 8 : 0);
			6: return 119 + ($urandom_range(0, 1) ? 1 : 0) + ($urandom_range(0, 1) ? 8 : 0);
			7: return 0;
			default: return $urandom_range(13, 70);
		endcase
	endfunction

	initial begin : stimulus
		bit first_pause;
		msg_ch.valid     <= 1'b0;
		msg_ch.action    <= ACT_ABSORB;
		msg_ch.data_byte <= 8'h00;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty message twice, byte extremes, "abc"
		send_request(ACT_FINISH, 8'hff);
		send_request(ACT_FINISH, 8'h00);
		send_request(ACT_ABSORB, 8'h00);
		send_request(ACT_FINISH, 8'h00);
		send_request(ACT_ABSORB, 8'hff);
		send_request(ACT_FINISH, 8'hff);
		send_request(ACT_ABSORB, 8'h61);
		send_request(ACT_ABSORB, 8'h62);
		send_request(ACT_ABSORB, 8'h63);
		send_request(ACT_FINISH, 8'h5a);

		// Random messages with random content
		random_phase = 1'b1;
		first_pause  = 1'b1;
		while (requests_taken < ITEM_TARGET) begin
			send_message(pick_length());
			if (first_pause || $urandom_range(0, 3) == 0) begin
				wait_drained();
				first_pause = 1'b0;
			end
		end

		// Drain and give the block time to show any stray word
		wait_drained();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (hasher_model.mismatches == 0 && hasher_model.pending() == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end
endmodule

// ===== filelist.f =====
src/sha_pkg.sv
src/sha_msg_if.sv
src/sha_dig_if.sv
src/sha_msg.sv
src/sha_round.sv
src/sha256_stream_hasher_top.sv
tb/testbench.sv
